### rtl/core/cevd_pkg.sv
// shared types and constants for the card event decoder
package cevd_pkg;

  localparam logic [7:0] TagPan = 8'h0A;
  localparam logic [7:0] TagAmount = 8'h10;
  localparam logic [7:0] TagSequence = 8'h18;
  localparam logic [7:0] GroupMask = 8'h7F;
  localparam logic [7:0] ContBit = 8'h80;
  localparam logic [3:0] LastGroup = 4'd9;  // group at bit 63, the tenth byte

  typedef enum logic [2:0] {
    PH_TAG1,
    PH_LEN,
    PH_PAN,
    PH_TAG2,
    PH_AMT,
    PH_TAG3,
    PH_SEQ,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAN = 2'd0,
    KIND_OK  = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_BAD_TAG  = 2'd1,
    CAUSE_TOO_LONG = 2'd2,
    CAUSE_TRUNC    = 2'd3
  } cause_e;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] accum;
    logic [3:0]  grp;
    logic [63:0] pan_rem;
    logic [63:0] amt;
  } state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  pan;
    logic [63:0] amount;
    logic [31:0] seq;
    cause_e      cause;
  } res_t;

endpackage

### rtl/core/cevd_step.sv
// next parser state and result for one input byte
module cevd_step (
  input  cevd_pkg::state_t state_i,
  input  logic [7:0]       in_byte_i,
  input  logic             last_byte_i,
  output cevd_pkg::state_t state_o,
  output cevd_pkg::res_t   res_o
);

  logic [5:0]       shamt;
  logic [63:0]      acc_new;
  logic             cont;
  logic             too_long;
  logic [7:0]       want;
  logic             err;
  logic             done_ok;
  cevd_pkg::cause_e cause;

  // bit position of the current varint group
  always_comb begin
    case (state_i.grp)
      4'd0: shamt = 6'd0;
      4'd1: shamt = 6'd7;
      4'd2: shamt = 6'd14;
      4'd3: shamt = 6'd21;
      4'd4: shamt = 6'd28;
      4'd5: shamt = 6'd35;
      4'd6: shamt = 6'd42;
      4'd7: shamt = 6'd49;
      4'd8: shamt = 6'd56;
      4'd9: shamt = 6'd63;
      default: shamt = 6'd0;
    endcase
  end

  // bits past 63 fall off the shift
  assign acc_new = state_i.accum | (64'(in_byte_i & cevd_pkg::GroupMask) << shamt);
  assign cont = (in_byte_i & cevd_pkg::ContBit) != 8'h00;
  assign too_long = cont && (state_i.grp == cevd_pkg::LastGroup);

  always_comb begin
    case (state_i.phase)
      cevd_pkg::PH_TAG1: want = cevd_pkg::TagPan;
      cevd_pkg::PH_TAG2: want = cevd_pkg::TagAmount;
      default:           want = cevd_pkg::TagSequence;
    endcase
  end

  always_comb begin
    state_o = state_i;
    res_o = '0;
    err = 1'b0;
    done_ok = 1'b0;
    cause = cevd_pkg::CAUSE_NONE;
    case (state_i.phase)
      cevd_pkg::PH_TAG1, cevd_pkg::PH_TAG2, cevd_pkg::PH_TAG3: begin
        if (in_byte_i != want) begin
          err = 1'b1;
          cause = cevd_pkg::CAUSE_BAD_TAG;
        end else begin
          state_o.phase = cevd_pkg::phase_e'(state_i.phase + 3'd1);
          state_o.accum = '0;
          state_o.grp = '0;
          if (last_byte_i) begin
            err = 1'b1;
            cause = cevd_pkg::CAUSE_TRUNC;
          end
        end
      end
      cevd_pkg::PH_LEN, cevd_pkg::PH_AMT, cevd_pkg::PH_SEQ: begin
        if (too_long) begin
          err = 1'b1;
          cause = cevd_pkg::CAUSE_TOO_LONG;
        end else if (!cont && state_i.phase == cevd_pkg::PH_SEQ) begin
          done_ok = 1'b1;
          res_o.valid = 1'b1;
          res_o.kind = cevd_pkg::KIND_OK;
          res_o.amount = state_i.amt;
          res_o.seq = acc_new[31:0];
        end else begin
          if (!cont) begin
            if (state_i.phase == cevd_pkg::PH_LEN) begin
              state_o.pan_rem = acc_new;
              state_o.phase = (acc_new == 64'd0) ? cevd_pkg::PH_TAG2 : cevd_pkg::PH_PAN;
            end else begin
              state_o.amt = acc_new;
              state_o.phase = cevd_pkg::PH_TAG3;
            end
            state_o.accum = '0;
            state_o.grp = '0;
          end else begin
            state_o.accum = acc_new;
            state_o.grp = state_i.grp + 4'd1;
          end
          if (last_byte_i) begin
            err = 1'b1;
            cause = cevd_pkg::CAUSE_TRUNC;
          end
        end
      end
      cevd_pkg::PH_PAN: begin
        if (last_byte_i) begin
          err = 1'b1;
          cause = cevd_pkg::CAUSE_TRUNC;
        end else begin
          state_o.pan_rem = state_i.pan_rem - 64'd1;
          if (state_i.pan_rem == 64'd1) begin
            state_o.phase = cevd_pkg::PH_TAG2;
          end
          res_o.valid = 1'b1;
          res_o.kind = cevd_pkg::KIND_PAN;
          res_o.pan = in_byte_i;
        end
      end
      default: begin
        if (last_byte_i) begin
          state_o = '0;
          state_o.phase = cevd_pkg::PH_TAG1;
        end
      end
    endcase

    if (err) begin
      res_o.valid = 1'b1;
      res_o.kind = cevd_pkg::KIND_ERR;
      res_o.cause = cause;
    end
    // any status rearms; later bytes are skipped up to the buffer end
    if (err || done_ok) begin
      state_o = '0;
      state_o.phase = last_byte_i ? cevd_pkg::PH_TAG1 : cevd_pkg::PH_SKIP;
    end
  end

endmodule

### rtl/core/protobuf_card_event_decoder.sv
// card event message decoder, top level with state and result registers
//
//   channel | direction | payload                                         | handshake
//   in      | input     | in_byte_i, last_byte_i                          | in_valid_i/in_ready_o
//   out     | output    | kind_o, pan_byte_o, amount_o, sequence_res_o,   | out_valid_o/out_ready_i
//           |           | error_cause_o                                   |
//
// one byte per cycle while the output is not stalled; a result appears in the cycle after the byte that causes it
// the byte's whole parse step is one combinational pass into the state register
// a byte is taken while the result register is empty or being drained
// when the output stalls with a result held, input stalls with it
// reset leaves the parser waiting for the first tag, no result pending
module protobuf_card_event_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  pan_byte_o,
  output logic [63:0] amount_o,
  output logic [31:0] sequence_res_o,
  output logic [1:0]  error_cause_o
);

  cevd_pkg::state_t state_q, state_d;
  cevd_pkg::res_t   res_d, res_q;
  logic             out_valid_q;
  logic             in_fire;

  cevd_step u_step (
    .state_i     (state_q),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && res_d.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_d.valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = res_q.kind;
  assign pan_byte_o = res_q.pan;
  assign amount_o = res_q.amount;
  assign sequence_res_o = res_q.seq;
  assign error_cause_o = res_q.cause;

`ifndef SYNTH
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_byte_i |=> state_q.phase == cevd_pkg::PH_TAG1)
    else $error("parser not rearmed after buffer end");

  a_pan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == cevd_pkg::PH_PAN |-> state_q.pan_rem != 64'd0)
    else $error("pan phase with no pan bytes left");

  a_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.grp <= cevd_pkg::LastGroup)
    else $error("varint group count out of range");

  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == cevd_pkg::KIND_ERR |-> error_cause_o != cevd_pkg::CAUSE_NONE)
    else $error("malformed status without a cause");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != cevd_pkg::KIND_ERR
    |-> error_cause_o == cevd_pkg::CAUSE_NONE)
    else $error("cause set on a non-error result");
`endif

endmodule
